/* hdl/cvnr_pkg.sv */
package cvnr_pkg;

  localparam int VoicePoolDef = 4;
  localparam int NumCfg = 6;

  localparam logic [2:0] CFG_LISTEN = 3'd0;
  localparam logic [2:0] CFG_SCALE  = 3'd1;
  localparam logic [2:0] CFG_ROOT   = 3'd2;
  localparam logic [2:0] CFG_CHORD  = 3'd3;
  localparam logic [2:0] CFG_HOLD   = 3'd4;
  localparam logic [2:0] CFG_ARP    = 3'd5;

  localparam logic [1:0] KIND_LOCAL_ON  = 2'd0;
  localparam logic [1:0] KIND_LOCAL_OFF = 2'd1;
  localparam logic [1:0] KIND_MIDI_ON   = 2'd2;
  localparam logic [1:0] KIND_MIDI_OFF  = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] channel;
    logic [6:0] note_number;
    logic [6:0] velocity;
  } in_word_t;

  typedef struct packed {
    logic       gate_on;
    logic [6:0] out_note;
    logic [6:0] out_velocity;
    logic       last;
  } out_word_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic       load;      // capture input word and compute quantized note
    logic       begin_on;  // chord note-on sequence (or latch set)
    logic       begin_off; // chord note-off sequence
    logic       use_latch; // off sequence takes the latched note
    logic       set_latch;
    logic       clr_latch;
    logic       step;      // process current chord interval
    logic       emit_main; // emit pending main word
  } cvnr_cmd_t;

  typedef struct packed {
    logic drop;        // wrong channel or ignored note-off
    logic is_on;       // event plays notes
    logic latch_set;   // latch flag of incoming note
    logic latching;
    logic chord_done;  // all intervals walked
    logic steal_pend;  // a steal word must go out first
    logic word_pend;   // a main word is pending
  } cvnr_sts_t;

  function automatic logic [11:0] scale_mask(input logic [3:0] s);
    logic [11:0] m;
    unique case (s)
      4'd1:  m = 12'h5AB;
      4'd2:  m = 12'h5AD;
      4'd3:  m = 12'h4AD;
      4'd4:  m = 12'h6AD;
      4'd5:  m = 12'h56B;
      4'd6:  m = 12'h2D7;
      4'd7:  m = 12'h5EB;
      4'd8:  m = 12'h52B;
      4'd9:  m = 12'h4A9;
      4'd10: m = 12'h4A5;
      4'd11: m = 12'h492;
      default: m = 12'hFFF;
    endcase
    return m;
  endfunction

  // Returns {count[2:0], i1, i2, i3} with intervals 4 bits each.
  function automatic logic [14:0] chord_shape(input logic [5:0] c);
    logic [14:0] r;
    if (c >= 6'd1 && c <= 6'd12) begin
      r = {3'd2, c[3:0], 4'd0, 4'd0};
    end else begin
      unique case (c)
        6'd13: r = {3'd3, 4'd4, 4'd7, 4'd0};
        6'd14: r = {3'd3, 4'd3, 4'd7, 4'd0};
        6'd15: r = {3'd3, 4'd3, 4'd6, 4'd0};
        6'd16: r = {3'd3, 4'd4, 4'd8, 4'd0};
        6'd17: r = {3'd3, 4'd2, 4'd7, 4'd0};
        6'd18: r = {3'd3, 4'd5, 4'd7, 4'd0};
        6'd19: r = {3'd4, 4'd4, 4'd7, 4'd11};
        6'd20: r = {3'd4, 4'd4, 4'd7, 4'd10};
        6'd21: r = {3'd4, 4'd3, 4'd7, 4'd10};
        6'd22: r = {3'd4, 4'd3, 4'd6, 4'd10};
        6'd23: r = {3'd4, 4'd3, 4'd6, 4'd9};
        6'd24: r = {3'd4, 4'd3, 4'd7, 4'd11};
        6'd25: r = {3'd4, 4'd4, 4'd8, 4'd11};
        6'd26: r = {3'd4, 4'd4, 4'd8, 4'd10};
        6'd27: r = {3'd4, 4'd4, 4'd7, 4'd14};
        6'd28: r = {3'd4, 4'd4, 4'd7, 4'd9};
        6'd29: r = {3'd4, 4'd3, 4'd7, 4'd9};
        6'd30: r = {3'd4, 4'd4, 4'd9, 4'd14};
        6'd31: r = {3'd4, 4'd5, 4'd7, 4'd10};
        6'd32: r = {3'd4, 4'd5, 4'd7, 4'd11};
        default: r = {3'd1, 4'd0, 4'd0, 4'd0};
      endcase
    end
    return r;
  endfunction

endpackage

/* hdl/chord_voice_note_router_top.sv */
// An accepted item passes the load, decode, step and emit states before its first
// result word is registered at the output; output stalls hold it. The next item is
// accepted after the controller walks all its chord intervals through the datapath
// and drains its words. A stolen voice adds a steal word; a drop ends at decode.
// Reset: synchronous, active low; clears config, state and control registers, voice count,
// latch flags and the per-note chord-mode valid bits. No clearing pass.
module chord_voice_note_router_top #(
  parameter int VOICE_POOL = cvnr_pkg::VoicePoolDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cvnr_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cvnr_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [5:0]          cfg_data
);
  import cvnr_pkg::*;

  cvnr_cmd_t cmd;
  cvnr_sts_t sts;
  logic      out_free;

  assign cfg_ready = 1'b1;

  cvnr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_free(out_free), .sts(sts), .cmd(cmd)
  );

  cvnr_dp #(.VOICE_POOL(VOICE_POOL)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_word(in_data),
    .cfg_we(cfg_valid && cfg_ready), .cfg_idx(cfg_index), .cfg_wdata(cfg_data),
    .cmd(cmd), .sts(sts), .out_valid(out_valid), .out_stall(out_stall),
    .out_free(out_free), .out_word(out_data)
  );

  a_one_start: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.begin_on && cmd.begin_off)) else $error("on and off started together");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_main |-> out_free) else $error("word emitted into a full output");

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> in_stall) else $error("input accepted mid item");

endmodule

/* hdl/cvnr_ctrl.sv */
module cvnr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                out_free,
  input  cvnr_pkg::cvnr_sts_t sts,
  output cvnr_pkg::cvnr_cmd_t cmd
);
  import cvnr_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DEC   = 6'b000010,
    S_STEP  = 6'b000100,
    S_EMIT  = 6'b001000,
    S_DRAIN = 6'b010000,
    S_WAIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.drop) begin
          state_nxt = S_IDLE;
        end else begin
          if (sts.is_on && sts.latching && sts.latch_set) begin
            cmd.begin_off = 1'b1;
            cmd.use_latch = 1'b1;
            cmd.clr_latch = 1'b1;
          end else if (sts.is_on) begin
            cmd.begin_on = 1'b1;
            cmd.set_latch = sts.latching;
          end else begin
            cmd.begin_off = 1'b1;
          end
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (sts.chord_done) begin
          state_nxt = S_DRAIN;
        end else begin
          cmd.step = 1'b1;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        // Steal word goes out first, then the chord word.
        if (!sts.word_pend) begin
          state_nxt = S_STEP;
        end else if (out_free) begin
          cmd.emit_main = 1'b1;
          if (!sts.steal_pend) state_nxt = S_STEP;
        end
      end
      S_DRAIN: begin
        cmd.emit_main = out_free && sts.word_pend;
        if (!sts.word_pend || out_free) state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

/* hdl/cvnr_dp.sv */
module cvnr_dp #(
  parameter int VOICE_POOL = cvnr_pkg::VoicePoolDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cvnr_pkg::in_word_t   in_word,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_idx,
  input  logic [5:0]           cfg_wdata,
  input  cvnr_pkg::cvnr_cmd_t  cmd,
  output cvnr_pkg::cvnr_sts_t  sts,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_free,
  output cvnr_pkg::out_word_t  out_word
);
  import cvnr_pkg::*;

  localparam int CW = $clog2(VOICE_POOL + 1);

  logic [3:0] listen_r, scale_r, root_r;
  logic [5:0] chord_r;
  logic       hold_r, arp_r;

  in_word_t   item_r;
  logic [6:0] qnote_r;
  logic [6:0] base_r;
  logic [6:0] vel_r;
  logic       gate_r;
  logic [14:0] shape_r;
  logic [2:0] idx_r;

  logic [127:0] latch_flag_r;
  logic [127:0] mode_val_r;
  logic [5:0]   mode_mem [128];
  logic [6:0]   latched_mem [128];
  logic [5:0]   mode_rd;
  logic [6:0]   latched_rd;

  logic [6:0]    voice_r [VOICE_POOL];
  logic [CW-1:0] vcount_r;

  // pending words: main and a steal word ahead of it
  logic       pend_r, steal_r;
  logic [6:0] pnote_r, snote_r;

  logic       ovalid_r;
  out_word_t  oword_r;

  // Quantizer, combinational from the captured item.
  logic [3:0] rootv, rel, up, dn, pc, qpc;
  logic [11:0] mask;
  logic [3:0] oct;
  logic [14:0] oct_prod;
  logic [7:0] qsum;
  logic       found;

  always_comb begin
    rootv = (root_r >= 4'd12) ? 4'd0 : root_r;
    mask = scale_mask(scale_r);
    // Octave by reciprocal multiplication: 171 / 2048 is close enough to 1/12 below 128.
    oct_prod = 15'(item_r.note_number) * 15'd171;
    oct = oct_prod[14:11];
    pc = 4'(item_r.note_number - 7'(oct * 4'd12));
    rel = (pc >= rootv) ? pc - rootv : 4'(pc + 4'd12 - rootv);
    qpc = rel;
    found = mask[rel];
    for (int d = 1; d <= 6; d++) begin
      up = 4'((5'(rel) + 5'(d)) >= 5'd12 ? 5'(rel) + 5'(d) - 5'd12 : 5'(rel) + 5'(d));
      dn = 4'((5'(rel) >= 5'(d)) ? 5'(rel) - 5'(d) : 5'(rel) + 5'd12 - 5'(d));
      if (!found && mask[up]) begin
        qpc = up; found = 1'b1;
      end else if (!found && mask[dn]) begin
        qpc = dn; found = 1'b1;
      end
    end
    qsum = 8'(rootv) + 8'(qpc) + 8'(oct * 4'd12);
  end

  logic [6:0] qnote_c;
  assign qnote_c = (scale_r == 4'd0 || scale_r >= 4'd12 || mask[rel]) ?
                   item_r.note_number : qsum[6:0];

  logic latching;
  assign latching = hold_r && !arp_r;

  // Load cycle registers the item; the decode cycle sees qnote_c.
  logic [6:0] inote;
  assign inote = item_r.note_number;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      listen_r <= '0; scale_r <= '0; root_r <= '0; chord_r <= '0;
      hold_r <= 1'b0; arp_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_LISTEN: listen_r <= cfg_wdata[3:0];
        CFG_SCALE:  scale_r  <= cfg_wdata[3:0];
        CFG_ROOT:   root_r   <= cfg_wdata[3:0];
        CFG_CHORD:  chord_r  <= cfg_wdata;
        CFG_HOLD:   hold_r   <= cfg_wdata[0];
        CFG_ARP:    arp_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic is_on;
  assign is_on = (item_r.kind == KIND_LOCAL_ON) || (item_r.kind == KIND_MIDI_ON);

  assign sts.is_on = is_on;
  assign sts.latching = latching;
  assign sts.latch_set = latch_flag_r[inote];
  assign sts.drop = (item_r.kind[1] && item_r.channel != listen_r) ||
                    (!is_on && latching);
  assign sts.chord_done = (idx_r >= shape_r[14:12]);
  assign sts.steal_pend = steal_r;
  assign sts.word_pend = pend_r || steal_r;

  // memory reads registered; address is the decode note (latched note on a latch release), data used at step
  logic [5:0] mode_c;
  logic [3:0] ival;
  logic [7:0] cn;
  logic       hit;
  logic [CW-1:0] hpos;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_word;
      latched_rd <= latched_mem[in_word.note_number];
    end
    mode_rd <= mode_mem[cmd.use_latch ? latched_rd : qnote_c];
    if (cmd.begin_on) begin
      mode_mem[qnote_c] <= chord_r;
      if (cmd.set_latch) latched_mem[inote] <= qnote_c;
    end
  end

  always_comb begin
    mode_c = mode_val_r[base_r] ? mode_rd : 6'd0;
    unique case (idx_r[1:0])
      2'd0: ival = 4'd0;
      2'd1: ival = shape_r[11:8];
      2'd2: ival = shape_r[7:4];
      default: ival = shape_r[3:0];
    endcase
    cn = 8'(base_r) + 8'(ival);
    hit = 1'b0;
    hpos = '0;
    for (int i = 0; i < VOICE_POOL; i++) begin
      if (!hit && CW'(i) < vcount_r && voice_r[i] == cn[6:0]) begin
        hit = 1'b1; hpos = CW'(i);
      end
    end
  end

  logic shape_ld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_flag_r <= '0;
      mode_val_r <= '0;
      vcount_r <= '0;
      pend_r <= 1'b0;
      steal_r <= 1'b0;
      idx_r <= 3'd0;
      shape_r <= {3'd0, 12'd0};
      shape_ld_r <= 1'b0;
    end else begin
      shape_ld_r <= 1'b0;
      if (cmd.begin_on || cmd.begin_off) begin
        idx_r <= 3'd0;
        gate_r <= cmd.begin_on;
        vel_r <= (item_r.kind == KIND_LOCAL_ON) ? 7'd100 : item_r.velocity;
        base_r <= cmd.use_latch ? latched_rd : qnote_c;
        if (cmd.set_latch) latch_flag_r[inote] <= 1'b1;
        if (cmd.clr_latch) latch_flag_r[inote] <= 1'b0;
        if (cmd.begin_on) begin
          mode_val_r[qnote_c] <= 1'b1;
          shape_r <= chord_shape(chord_r);
        end else begin
          // real shape comes from the stored mode next cycle
          shape_r <= {3'd7, 12'd0};
          shape_ld_r <= 1'b1;
        end
      end
      if (shape_ld_r) begin
        shape_r <= chord_shape(mode_c);
        mode_val_r[base_r] <= 1'b0;
      end
      if (cmd.step) begin
        idx_r <= idx_r + 3'd1;
        if (!cn[7]) begin
          pend_r <= 1'b1;
          pnote_r <= cn[6:0];
          if (gate_r) begin
            if (!hit) begin
              if (vcount_r >= CW'(VOICE_POOL)) begin
                steal_r <= 1'b1;
                snote_r <= voice_r[0];
                for (int i = 0; i < VOICE_POOL - 1; i++) voice_r[i] <= voice_r[i+1];
                voice_r[VOICE_POOL-1] <= cn[6:0];
              end else begin
                voice_r[vcount_r[$clog2(VOICE_POOL)-((VOICE_POOL>1)?1:0):0]] <= cn[6:0];
                vcount_r <= vcount_r + CW'(1);
              end
            end
          end else if (hit) begin
            for (int i = 0; i < VOICE_POOL - 1; i++)
              if (CW'(i) >= hpos) voice_r[i] <= voice_r[i+1];
            vcount_r <= vcount_r - CW'(1);
          end
        end
      end
      if (cmd.emit_main) begin
        if (steal_r) steal_r <= 1'b0;
        else pend_r <= 1'b0;
      end
    end
  end

  // A chord word is marked last only if it is the final one of the item.
  logic more_after;
  always_comb begin
    more_after = 1'b0;
    for (int k = 1; k < 4; k++) begin
      if (3'(k) >= idx_r && 3'(k) < shape_r[14:12]) begin
        unique case (k)
          1: if (8'(base_r) + 8'(shape_r[11:8]) < 8'd128) more_after = 1'b1;
          2: if (8'(base_r) + 8'(shape_r[7:4]) < 8'd128) more_after = 1'b1;
          default: if (8'(base_r) + 8'(shape_r[3:0]) < 8'd128) more_after = 1'b1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else begin
      if (ovalid_r && !out_stall) ovalid_r <= 1'b0;
      if (cmd.emit_main) begin
        ovalid_r <= 1'b1;
        if (steal_r) begin
          oword_r <= '{gate_on: 1'b0, out_note: snote_r, out_velocity: 7'd0, last: 1'b0};
        end else begin
          oword_r <= '{gate_on: gate_r, out_note: pnote_r,
                       out_velocity: gate_r ? vel_r : 7'd0,
                       last: !more_after};
        end
      end
    end
  end

  assign out_free = !ovalid_r || !out_stall;
  assign out_valid = ovalid_r;
  assign out_word = oword_r;

endmodule
